/* rtl/spi_pkg.sv */
`default_nettype none
package spi_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_PX = 3'd0;
    localparam logic [2:0] CFG_PY = 3'd1;
    localparam logic [2:0] CFG_PZ = 3'd2;
    localparam logic [2:0] CFG_NX = 3'd3;
    localparam logic [2:0] CFG_NY = 3'd4;
    localparam logic [2:0] CFG_NZ = 3'd5;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW = 2;

    // Square root steps over a 64-bit radicand
    localparam int SQRT_STEPS = 32;

    // Classified segment, front to back
    typedef struct packed {
        logic             hit;
        logic [2:0][31:0] v0;
        logic [2:0][32:0] dir;
        logic [31:0]      a0;
        logic [31:0]      a1;
        logic [63:0]      sq;
    } t_job;

    // What the back carries along its stages
    typedef struct packed {
        logic             hit;
        logic [2:0][31:0] v0;
        logic [2:0][32:0] dir;
    } t_bjob;

    function automatic logic [31:0] sat32(input logic signed [63:0] x);
        logic [31:0] r;
        if (x > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'h7FFF_FFFF;
        end else if (x < -64'sh0000_0000_8000_0000) begin
            r = 32'h8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/spi_seg_if.sv */
`default_nettype none
interface spi_seg_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;

    modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                    input ready);
    modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  output ready);
endinterface
`default_nettype wire

/* rtl/spi_res_if.sv */
`default_nettype none
interface spi_res_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic signed [31:0] cross_x;
    logic signed [31:0] cross_y;
    logic signed [31:0] cross_z;

    modport source (output valid, hit, cross_x, cross_y, cross_z, input ready);
    modport sink (input valid, hit, cross_x, cross_y, cross_z, output ready);
endinterface
`default_nettype wire

/* rtl/spi_front.sv */
`default_nettype none
module spi_front #(
    parameter int FRAC_BITS = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [spi_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire [spi_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    spi_seg_if.sink                          i_seg,
    output spi_pkg::t_job                    o_job,
    output logic                             o_push,
    input  wire                              i_full
);

    logic signed [31:0] r_p [3];
    logic signed [17:0] r_n [3];

    logic               r1_v, r2_v, r3_v;
    logic signed [32:0] r1_d0 [3];
    logic signed [32:0] r1_d1 [3];
    logic signed [32:0] r1_dir [3];
    logic [31:0]        r1_v0 [3];
    logic signed [50:0] r2_p0 [3];
    logic signed [50:0] r2_p1 [3];
    logic signed [63:0] r2_sq [3];
    logic signed [32:0] r2_dir [3];
    logic [31:0]        r2_v0 [3];
    spi_pkg::t_job      r3_job;

    logic               fe;
    logic signed [31:0] v0 [3];
    logic signed [31:0] v1 [3];
    logic signed [52:0] acc0, acc1;
    logic signed [31:0] d0, d1;
    logic signed [32:0] ad0, ad1;
    spi_pkg::t_job      n_job;

    assign fe = !r3_v || !i_full;
    assign i_seg.ready = fe;
    assign o_push = r3_v && !i_full;
    assign o_job = r3_job;

    assign v0[0] = i_seg.start_x;
    assign v0[1] = i_seg.start_y;
    assign v0[2] = i_seg.start_z;
    assign v1[0] = i_seg.end_x;
    assign v1[1] = i_seg.end_y;
    assign v1[2] = i_seg.end_z;

    // plane registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p[0] <= '0;
            r_p[1] <= '0;
            r_p[2] <= '0;
            r_n[0] <= '0;
            r_n[1] <= 18'(64'd1 << FRAC_BITS);
            r_n[2] <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                spi_pkg::CFG_PX: r_p[0] <= i_cfg_data;
                spi_pkg::CFG_PY: r_p[1] <= i_cfg_data;
                spi_pkg::CFG_PZ: r_p[2] <= i_cfg_data;
                spi_pkg::CFG_NX: r_n[0] <= i_cfg_data[17:0];
                spi_pkg::CFG_NY: r_n[1] <= i_cfg_data[17:0];
                spi_pkg::CFG_NZ: r_n[2] <= i_cfg_data[17:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (fe) begin
            r1_v <= i_seg.valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    // stage 1: differences
    always_ff @(posedge i_clk) begin
        if (fe) begin
            for (int i = 0; i < 3; i++) begin
                r1_d0[i]  <= 33'(v0[i]) - 33'(r_p[i]);
                r1_d1[i]  <= 33'(v1[i]) - 33'(r_p[i]);
                r1_dir[i] <= 33'(v1[i]) - 33'(v0[i]);
                r1_v0[i]  <= v0[i];
            end
        end
    end

    // stage 2: products and squares
    always_ff @(posedge i_clk) begin
        if (fe) begin
            for (int i = 0; i < 3; i++) begin
                r2_p0[i]  <= r_n[i] * r1_d0[i];
                r2_p1[i]  <= r_n[i] * r1_d1[i];
                r2_sq[i]  <= $signed(spi_pkg::sat32(64'(r1_dir[i])))
                           * $signed(spi_pkg::sat32(64'(r1_dir[i])));
                r2_dir[i] <= r1_dir[i];
                r2_v0[i]  <= r1_v0[i];
            end
        end
    end

    // stage 3: distances and side test
    always_comb begin
        acc0 = 53'(r2_p0[0]) + 53'(r2_p0[1]) + 53'(r2_p0[2]);
        acc1 = 53'(r2_p1[0]) + 53'(r2_p1[1]) + 53'(r2_p1[2]);
        d0 = $signed(spi_pkg::sat32(64'(acc0 >>> FRAC_BITS)));
        d1 = $signed(spi_pkg::sat32(64'(acc1 >>> FRAC_BITS)));
        ad0 = (d0 < 0) ? -33'(d0) : 33'(d0);
        ad1 = (d1 < 0) ? -33'(d1) : 33'(d1);
        n_job.hit = (d0 <= 0) != (d1 <= 0);
        for (int i = 0; i < 3; i++) begin
            n_job.v0[i]  = r2_v0[i];
            n_job.dir[i] = r2_dir[i];
        end
        n_job.a0 = ad0[31:0];
        n_job.a1 = ad1[31:0];
        n_job.sq = $unsigned(r2_sq[0]) + $unsigned(r2_sq[1]) + $unsigned(r2_sq[2]);
    end

    always_ff @(posedge i_clk) begin
        if (fe) begin
            r3_job <= n_job;
        end
    end

endmodule
`default_nettype wire

/* rtl/spi_fifo.sv */
`default_nettype none
module spi_fifo (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_push,
    input  spi_pkg::t_job             i_data,
    input  wire                       i_pop,
    output spi_pkg::t_job             o_data,
    output logic                      o_empty,
    output logic                      o_full
);

    spi_pkg::t_job                r_mem [spi_pkg::FIFO_DEPTH];
    logic [spi_pkg::FIFO_AW-1:0]  r_wp, r_rp;
    logic [spi_pkg::FIFO_AW:0]    r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (spi_pkg::FIFO_AW+1)'(spi_pkg::FIFO_DEPTH));
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/spi_back.sv */
`default_nettype none
module spi_back #(
    parameter int FRAC_BITS = 16
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  spi_pkg::t_job  i_job,
    input  wire            i_empty,
    output logic           o_pop,
    spi_res_if.source      o_res
);

    localparam int TW = FRAC_BITS + 1;
    localparam int NW = 33 + FRAC_BITS;
    localparam int NS = spi_pkg::SQRT_STEPS;
    localparam int EPS_Q = ((2 ** FRAC_BITS) + 500) / 1000;
    localparam int PW = 34 + FRAC_BITS;

    logic be;
    assign be = !o_res.valid || o_res.ready;
    assign o_pop = be && !i_empty;

    spi_pkg::t_bjob in_bjob;
    assign in_bjob.hit = i_job.hit;
    assign in_bjob.v0  = i_job.v0;
    assign in_bjob.dir = i_job.dir;

    // square root and t division side by side
    logic           r_sv   [1:NS];
    spi_pkg::t_bjob r_sj   [1:NS];
    logic [63:0]    r_rem  [1:NS];
    logic [63:0]    r_root [1:NS];
    logic [NW-1:0]  r_n1   [1:NS];
    logic [NW-1:0]  r_d1   [1:NS];
    logic [TW-1:0]  r_q1   [1:NS];

    for (genvar k = 0; k < NS; k++) begin : g_sq
        logic           c_v;
        spi_pkg::t_bjob c_j;
        logic [63:0]    c_rem, c_root, n_rem, n_root, bitv, trial;
        logic [NW-1:0]  c_n, c_d, n_n;
        logic [TW-1:0]  c_q, n_q;

        if (k == 0) begin : g_in
            assign c_v    = !i_empty;
            assign c_j    = in_bjob;
            assign c_rem  = i_job.sq;
            assign c_root = '0;
            assign c_n    = NW'(i_job.a0) << FRAC_BITS;
            assign c_d    = NW'(i_job.a0) + NW'(i_job.a1);
            assign c_q    = '0;
        end else begin : g_mid
            assign c_v    = r_sv[k];
            assign c_j    = r_sj[k];
            assign c_rem  = r_rem[k];
            assign c_root = r_root[k];
            assign c_n    = r_n1[k];
            assign c_d    = r_d1[k];
            assign c_q    = r_q1[k];
        end

        assign bitv  = 64'd1 << (62 - 2 * k);
        assign trial = c_root + bitv;

        always_comb begin
            if (c_rem >= trial) begin
                n_rem  = c_rem - trial;
                n_root = (c_root >> 1) + bitv;
            end else begin
                n_rem  = c_rem;
                n_root = c_root >> 1;
            end
        end

        if (k < TW) begin : g_div
            logic [NW-1:0] dsh;
            assign dsh = c_d << (TW - 1 - k);
            always_comb begin
                if (c_n >= dsh) begin
                    n_n = c_n - dsh;
                    n_q = c_q | (TW'(1) << (TW - 1 - k));
                end else begin
                    n_n = c_n;
                    n_q = c_q;
                end
            end
        end else begin : g_pass
            assign n_n = c_n;
            assign n_q = c_q;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k+1] <= 1'b0;
            end else if (be) begin
                r_sv[k+1] <= c_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (be) begin
                r_sj[k+1]   <= c_j;
                r_rem[k+1]  <= n_rem;
                r_root[k+1] <= n_root;
                r_n1[k+1]   <= n_n;
                r_d1[k+1]   <= c_d;
                r_q1[k+1]   <= n_q;
            end
        end
    end

    // L*t
    logic           rl_v;
    spi_pkg::t_bjob rl_j;
    logic [30:0]    rl_lt;
    logic [TW-1:0]  rl_t;
    logic [30:0]    len;
    logic [31+TW-1:0] lprod;

    assign len   = (r_root[NS] > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : r_root[NS][30:0];
    assign lprod = (31 + TW)'(len) * (31 + TW)'(r_q1[NS]);

    // t*(Lt-eps)
    logic           rm_v;
    spi_pkg::t_bjob rm_j;
    logic [NW-1:0]  rm_num;
    logic [30:0]    rm_lt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rl_v <= 1'b0;
            rm_v <= 1'b0;
        end else if (be) begin
            rl_v <= r_sv[NS];
            rm_v <= rl_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (be) begin
            rl_j  <= r_sj[NS];
            rl_lt <= lprod[FRAC_BITS +: 31];
            rl_t  <= r_q1[NS];
            rm_j  <= rl_j;
            // short crossing: zero numerator over a nonzero divisor gives t' = 0
            if (rl_lt > 31'(EPS_Q)) begin
                rm_lt  <= rl_lt;
                rm_num <= NW'(rl_t) * NW'(rl_lt - 31'(EPS_Q));
            end else begin
                rm_lt  <= 31'd1;
                rm_num <= '0;
            end
        end
    end

    // second division: t' = num / Lt
    logic           r_dv [1:TW];
    spi_pkg::t_bjob r_dj [1:TW];
    logic [NW-1:0]  r_n2 [1:TW];
    logic [NW-1:0]  r_d2 [1:TW];
    logic [TW-1:0]  r_q2 [1:TW];

    for (genvar k = 0; k < TW; k++) begin : g_dv
        logic           c_v;
        spi_pkg::t_bjob c_j;
        logic [NW-1:0]  c_n, c_d, n_n, dsh;
        logic [TW-1:0]  c_q, n_q;

        if (k == 0) begin : g_in
            assign c_v = rm_v;
            assign c_j = rm_j;
            assign c_n = rm_num;
            assign c_d = NW'(rm_lt);
            assign c_q = '0;
        end else begin : g_mid
            assign c_v = r_dv[k];
            assign c_j = r_dj[k];
            assign c_n = r_n2[k];
            assign c_d = r_d2[k];
            assign c_q = r_q2[k];
        end

        assign dsh = c_d << (TW - 1 - k);

        always_comb begin
            if (c_n >= dsh) begin
                n_n = c_n - dsh;
                n_q = c_q | (TW'(1) << (TW - 1 - k));
            end else begin
                n_n = c_n;
                n_q = c_q;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else if (be) begin
                r_dv[k+1] <= c_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (be) begin
                r_dj[k+1] <= c_j;
                r_n2[k+1] <= n_n;
                r_d2[k+1] <= c_d;
                r_q2[k+1] <= n_q;
            end
        end
    end

    // dir * t'
    logic               rp_v;
    spi_pkg::t_bjob     rp_j;
    logic signed [PW-1:0] rp_prod [3];

    // output register
    logic               r_ov;
    logic               r_hit;
    logic [31:0]        r_cross [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rp_v <= 1'b0;
            r_ov <= 1'b0;
        end else if (be) begin
            rp_v <= r_dv[TW];
            r_ov <= rp_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (be) begin
            rp_j <= r_dj[TW];
            for (int i = 0; i < 3; i++) begin
                rp_prod[i] <= PW'($signed(r_dj[TW].dir[i])) * PW'($signed({1'b0, r_q2[TW]}));
            end
            r_hit <= rp_j.hit;
            for (int i = 0; i < 3; i++) begin
                if (rp_j.hit) begin
                    r_cross[i] <= spi_pkg::sat32(64'($signed(rp_j.v0[i]))
                                               + 64'(rp_prod[i] >>> FRAC_BITS));
                end else begin
                    r_cross[i] <= '0;
                end
            end
        end
    end

    assign o_res.valid   = r_ov;
    assign o_res.hit     = r_hit;
    assign o_res.cross_x = r_cross[0];
    assign o_res.cross_y = r_cross[1];
    assign o_res.cross_z = r_cross[2];

endmodule
`default_nettype wire

/* rtl/segment_plane_intersect.sv */
// Fixed point with FRAC_BITS fraction bits: 32-bit values read as Q16.16 at the default.
// Throughput: one segment per cycle; the back pipeline advances whenever the
// output register is empty or being taken, the front whenever the queue has room.
// Reset: synchronous, active low; clears all valid flags and the queue, and sets
// the plane to point (0,0,0) with normal (0,1.0,0).
`default_nettype none
module segment_plane_intersect #(
    parameter int FRAC_BITS = 16
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    spi_seg_if.sink                        i_seg,
    spi_res_if.source                      o_res,
    input  wire                            i_cfg_we,
    input  wire [spi_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [spi_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    // Front: three stages (plane differences, dot products and squared
    // direction, then distances, side test and |d|). Back: 32 sqrt steps with
    // the t division folded in, L*t, t*(Lt-eps), a second restoring divider,
    // dir*t', then the saturating add into the output register.

    spi_pkg::t_job f_job, q_job;
    logic          f_push, q_full, q_empty, q_pop;

    spi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_seg      (i_seg),
        .o_job      (f_job),
        .o_push     (f_push),
        .i_full     (q_full)
    );

    // short queue lets front and back stall on their own
    spi_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_job),
        .i_pop   (q_pop),
        .o_data  (q_job),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    spi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (q_job),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .o_res   (o_res)
    );

endmodule
`default_nettype wire
